FILE: src/qrj_pkg.sv
package qrj_pkg;

  localparam int NUM_ELEMS = 24;
  localparam int IDX_W     = 5;
  localparam logic [IDX_W-1:0] LAST_IDX = 5'd23;

  localparam int IN_W   = 16;  // Q2.14 component
  localparam int SQ_W   = 31;  // square of a component, unsigned
  localparam int S_W    = 33;  // squared norm
  localparam int L_W    = 34;  // signed sum of squares
  localparam int XL_W   = 50;  // component times sum of squares
  localparam int PAIR_W = 32;  // product of two components
  localparam int TRI_W  = 48;  // product of three components
  localparam int V_W    = 52;  // scaled polynomial
  localparam int M_W    = 51;  // polynomial magnitude
  localparam int D_W    = 65;  // squared norm, squared
  localparam int Q_W    = 33;  // quotient bits kept
  localparam int OUT_W  = 32;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  // component select
  localparam logic [1:0] X_A = 2'd0;
  localparam logic [1:0] X_B = 2'd1;
  localparam logic [1:0] X_C = 2'd2;
  localparam logic [1:0] X_D = 2'd3;

  // sign of a term
  localparam logic [1:0] SG_Z = 2'd0;
  localparam logic [1:0] SG_P = 2'd1;
  localparam logic [1:0] SG_N = 2'd2;

  // triple product select
  localparam logic [1:0] T_ABC = 2'd0;
  localparam logic [1:0] T_ABD = 2'd1;
  localparam logic [1:0] T_ACD = 2'd2;
  localparam logic [1:0] T_BCD = 2'd3;

  // v = (quad ? 4 : 2) * x * (sa*a2 + sb*b2 + sc*c2 + sd*d2) + 4 * ts * triple
  typedef struct packed {
    logic [1:0] xsel;
    logic [1:0] sa;
    logic [1:0] sb;
    logic [1:0] sc;
    logic [1:0] sd;
    logic       quad;
    logic [1:0] tsel;
    logic [1:0] tsgn;
  } elem_cfg_t;

  function automatic elem_cfg_t elem_cfg(input logic [IDX_W-1:0] k);
    elem_cfg_t c;
    case (k)
      5'd0:  c = '{X_A, SG_Z, SG_Z, SG_P, SG_P, 1'b1, T_ABC, SG_Z};
      5'd1:  c = '{X_D, SG_N, SG_P, SG_P, SG_P, 1'b0, T_ABC, SG_N};
      5'd2:  c = '{X_D, SG_P, SG_N, SG_N, SG_N, 1'b0, T_ABC, SG_N};
      5'd3:  c = '{X_A, SG_Z, SG_P, SG_Z, SG_P, 1'b1, T_ABC, SG_Z};
      5'd4:  c = '{X_C, SG_N, SG_P, SG_P, SG_P, 1'b0, T_ABD, SG_N};
      5'd5:  c = '{X_B, SG_P, SG_N, SG_N, SG_N, 1'b0, T_ACD, SG_N};
      5'd6:  c = '{X_B, SG_Z, SG_Z, SG_P, SG_P, 1'b1, T_ABC, SG_Z};
      5'd7:  c = '{X_C, SG_P, SG_N, SG_P, SG_P, 1'b0, T_ABD, SG_N};
      5'd8:  c = '{X_C, SG_P, SG_N, SG_P, SG_P, 1'b0, T_ABD, SG_P};
      5'd9:  c = '{X_B, SG_N, SG_Z, SG_N, SG_Z, 1'b1, T_ABC, SG_Z};
      5'd10: c = '{X_D, SG_P, SG_N, SG_P, SG_P, 1'b0, T_ABC, SG_N};
      5'd11: c = '{X_A, SG_N, SG_P, SG_N, SG_N, 1'b0, T_BCD, SG_N};
      5'd12: c = '{X_C, SG_N, SG_N, SG_Z, SG_Z, 1'b1, T_ABC, SG_Z};
      5'd13: c = '{X_B, SG_P, SG_P, SG_N, SG_P, 1'b0, T_ACD, SG_N};
      5'd14: c = '{X_B, SG_P, SG_P, SG_N, SG_P, 1'b0, T_ACD, SG_P};
      5'd15: c = '{X_C, SG_Z, SG_P, SG_Z, SG_P, 1'b1, T_ABC, SG_Z};
      5'd16: c = '{X_A, SG_P, SG_P, SG_N, SG_P, 1'b0, T_BCD, SG_N};
      5'd17: c = '{X_D, SG_P, SG_P, SG_N, SG_P, 1'b0, T_ABC, SG_P};
      5'd18: c = '{X_D, SG_N, SG_N, SG_Z, SG_Z, 1'b1, T_ABC, SG_Z};
      5'd19: c = '{X_A, SG_P, SG_P, SG_P, SG_N, 1'b0, T_BCD, SG_N};
      5'd20: c = '{X_A, SG_N, SG_N, SG_N, SG_P, 1'b0, T_BCD, SG_N};
      5'd21: c = '{X_D, SG_N, SG_Z, SG_N, SG_Z, 1'b1, T_ABC, SG_Z};
      5'd22: c = '{X_B, SG_P, SG_P, SG_P, SG_N, 1'b0, T_ACD, SG_N};
      5'd23: c = '{X_C, SG_P, SG_P, SG_P, SG_N, 1'b0, T_ABD, SG_P};
      default: c = '{X_A, SG_Z, SG_Z, SG_Z, SG_Z, 1'b0, T_ABC, SG_Z};
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic [IDX_W-1:0]      idx;
    logic                  last;
    logic                  zero;
    logic signed [V_W-1:0] v;
    logic [D_W-1:0]        d;
  } mid_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             zero;
    logic [OUT_W-1:0] value;
  } out_entry_t;

endpackage

FILE: src/quaternion_rotation_jacobian.sv
// Quaternion rotation Jacobian. Push one quaternion (w,x,y,z, signed Q2.14,
// need not be unit length) and pop 24 results: the derivatives of the first
// two rows of its normalized rotation matrix with respect to each component,
// in order element_index 0..23 (row + 2*column + 6*component), signed Q16.16,
// rounded to nearest with ties away from zero and saturated; is_last marks
// the 24th. A zero quaternion still yields 24 results, each with value 0 and
// zero_norm set. The front end issues one element per cycle, while the queue
// to the back end is not full, from a held copy of the quaternion, and the
// back end retires one element per cycle, while the result queue is not full,
// through a 33-step pipelined restoring divider by the squared norm squared.
// The front end keeps a one-deep input slot, so the next quaternion can be
// pushed while the current one is still issuing; a queue between front and
// back end and a small result queue let each side stall without stopping
// the other.
module quaternion_rotation_jacobian #(
  parameter int MidDepth = 4,
  parameter int OutDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         element_index_o,
  output logic [31:0]        deriv_value_o,
  output logic               is_last_o,
  output logic               zero_norm_o
);

  localparam int MidW = $bits(qrj_pkg::mid_entry_t);
  localparam int OutW = $bits(qrj_pkg::out_entry_t);

  // front end to queue
  logic mid_push, mid_full, mid_pop, mid_empty;
  qrj_pkg::mid_entry_t mid_in, mid_out;

  // back end to result queue
  logic out_push, out_full;
  qrj_pkg::out_entry_t out_in, out_head;

  // Accept a request, expand it into 24 element requests.
  qrj_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .q_w_i      (q_w_i),
    .q_x_i      (q_x_i),
    .q_y_i      (q_y_i),
    .q_z_i      (q_z_i),
    .mid_push_o (mid_push),
    .mid_full_i (mid_full),
    .mid_data_o (mid_in)
  );

  // Hold element requests between the polynomial and divider sides.
  qrj_fifo #(
    .Width (MidW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_out)
  );

  // Divide, round and saturate one element per cycle while the result queue has room.
  qrj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .mid_data_i  (mid_out),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_data_o  (out_in)
  );

  // Hold finished results until popped.
  qrj_fifo #(
    .Width (OutW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_head)
  );

  assign element_index_o = out_head.idx;
  assign deriv_value_o   = out_head.value;
  assign is_last_o       = out_head.last;
  assign zero_norm_o     = out_head.zero;

endmodule

FILE: src/qrj_fifo.sv
module qrj_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/qrj_front.sv
module qrj_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic signed [15:0]     q_w_i,
  input  logic signed [15:0]     q_x_i,
  input  logic signed [15:0]     q_y_i,
  input  logic signed [15:0]     q_z_i,
  output logic                   mid_push_o,
  input  logic                   mid_full_i,
  output qrj_pkg::mid_entry_t    mid_data_o
);

  // input capture
  logic in_valid_q, in_valid_d;
  logic signed [qrj_pkg::IN_W-1:0] in_w_q, in_x_q, in_y_q, in_z_q;
  logic accept;

  // item held while its elements issue
  logic item_valid_q, item_valid_d;
  logic [qrj_pkg::IDX_W-1:0] item_idx_q, item_idx_d;
  logic signed [qrj_pkg::IN_W-1:0] a_q, b_q, c_q, d_q;
  logic [qrj_pkg::SQ_W-1:0] sqa_q, sqb_q, sqc_q, sqd_q;
  logic signed [qrj_pkg::PAIR_W-1:0] ab_q, cd_q;
  logic signed [31:0] p_aa, p_bb, p_cc, p_dd;
  logic load, issue, item_done, fadv;

  // issue stage
  qrj_pkg::elem_cfg_t cfg;
  logic signed [qrj_pkg::IN_W-1:0]   sel_x, sel_y;
  logic signed [qrj_pkg::L_W-1:0]    sel_l;
  logic signed [qrj_pkg::PAIR_W-1:0] sel_pair;
  logic [qrj_pkg::S_W-1:0]           norm_sq;

  logic f1_valid_q;
  logic signed [qrj_pkg::IN_W-1:0]   f1_x_q, f1_y_q;
  logic signed [qrj_pkg::L_W-1:0]    f1_l_q;
  logic signed [qrj_pkg::PAIR_W-1:0] f1_pair_q;
  logic [1:0]                        f1_tsgn_q;
  logic                              f1_quad_q, f1_last_q;
  logic [qrj_pkg::IDX_W-1:0]         f1_idx_q;
  logic [qrj_pkg::S_W-1:0]           f1_s_q;

  // product stage
  logic [16:0] s_hi;
  logic [15:0] s_lo;
  logic f2_valid_q;
  logic signed [qrj_pkg::XL_W-1:0]  f2_xl_q, f2_xl_d;
  logic signed [qrj_pkg::TRI_W-1:0] f2_tri_q, f2_tri_d;
  logic [1:0]                       f2_tsgn_q;
  logic                             f2_quad_q, f2_last_q, f2_zero_q;
  logic [qrj_pkg::IDX_W-1:0]        f2_idx_q;
  logic [32:0] f2_hh_q, f2_hh_d, f2_hl_q, f2_hl_d;
  logic [31:0] f2_ll_q, f2_ll_d;

  // combine stage
  logic signed [qrj_pkg::V_W-1:0] xl_ext, xl_scaled, tri_ext, v_sum;
  logic f3_valid_q;
  qrj_pkg::mid_entry_t f3_q, f3_d;

  function automatic logic signed [qrj_pkg::L_W-1:0] sgn_term(
    input logic [1:0] code,
    input logic [qrj_pkg::SQ_W-1:0] sq
  );
    logic signed [qrj_pkg::L_W-1:0] e;
    e = signed'({3'b000, sq});
    case (code)
      qrj_pkg::SG_P: return e;
      qrj_pkg::SG_N: return -e;
      default:       return '0;
    endcase
  endfunction

  assign fadv       = !f3_valid_q || !mid_full_i;
  assign mid_push_o = f3_valid_q && !mid_full_i;
  assign mid_data_o = f3_q;

  assign full_o    = in_valid_q;
  assign accept    = push_i && !in_valid_q;
  assign issue     = item_valid_q && fadv;
  assign item_done = issue && (item_idx_q == qrj_pkg::LAST_IDX);
  assign load      = in_valid_q && (!item_valid_q || item_done);

  assign p_aa = in_w_q * in_w_q;
  assign p_bb = in_x_q * in_x_q;
  assign p_cc = in_y_q * in_y_q;
  assign p_dd = in_z_q * in_z_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
    item_valid_d = item_valid_q;
    item_idx_d   = item_idx_q;
    if (load) begin
      item_valid_d = 1'b1;
      item_idx_d   = '0;
    end else if (item_done) begin
      item_valid_d = 1'b0;
    end else if (issue) begin
      item_idx_d = item_idx_q + 1'b1;
    end
  end

  // select operands of the current element
  always_comb begin
    cfg = qrj_pkg::elem_cfg(item_idx_q);
    case (cfg.xsel)
      qrj_pkg::X_A: sel_x = a_q;
      qrj_pkg::X_B: sel_x = b_q;
      qrj_pkg::X_C: sel_x = c_q;
      default:      sel_x = d_q;
    endcase
    case (cfg.tsel)
      qrj_pkg::T_ABC: begin
        sel_pair = ab_q;
        sel_y    = c_q;
      end
      qrj_pkg::T_ABD: begin
        sel_pair = ab_q;
        sel_y    = d_q;
      end
      qrj_pkg::T_ACD: begin
        sel_pair = cd_q;
        sel_y    = a_q;
      end
      default: begin
        sel_pair = cd_q;
        sel_y    = b_q;
      end
    endcase
    sel_l = sgn_term(cfg.sa, sqa_q) + sgn_term(cfg.sb, sqb_q)
          + sgn_term(cfg.sc, sqc_q) + sgn_term(cfg.sd, sqd_q);
    norm_sq = {2'b00, sqa_q} + {2'b00, sqb_q} + {2'b00, sqc_q} + {2'b00, sqd_q};
  end

  // products; the squared norm is split so each partial stays narrow
  always_comb begin
    s_hi     = f1_s_q[32:16];
    s_lo     = f1_s_q[15:0];
    f2_xl_d  = f1_x_q * f1_l_q;
    f2_tri_d = f1_pair_q * f1_y_q;
    f2_hh_d  = s_hi * s_hi;
    f2_hl_d  = s_hi * s_lo;
    f2_ll_d  = s_lo * s_lo;
  end

  always_comb begin
    xl_ext    = {{(qrj_pkg::V_W - qrj_pkg::XL_W){f2_xl_q[qrj_pkg::XL_W-1]}}, f2_xl_q};
    xl_scaled = f2_quad_q ? (xl_ext <<< 2) : (xl_ext <<< 1);
    tri_ext   = {{(qrj_pkg::V_W - qrj_pkg::TRI_W){f2_tri_q[qrj_pkg::TRI_W-1]}}, f2_tri_q};
    case (f2_tsgn_q)
      qrj_pkg::SG_P: v_sum = xl_scaled + (tri_ext <<< 2);
      qrj_pkg::SG_N: v_sum = xl_scaled - (tri_ext <<< 2);
      default:       v_sum = xl_scaled;
    endcase
    f3_d.idx  = f2_idx_q;
    f3_d.last = f2_last_q;
    f3_d.zero = f2_zero_q;
    f3_d.v    = v_sum;
    f3_d.d    = {f2_hh_q, 32'b0} + {15'b0, f2_hl_q, 17'b0} + {33'b0, f2_ll_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      item_valid_q <= 1'b0;
      item_idx_q   <= '0;
      f1_valid_q   <= 1'b0;
      f2_valid_q   <= 1'b0;
      f3_valid_q   <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      item_valid_q <= item_valid_d;
      item_idx_q   <= item_idx_d;
      if (fadv) begin
        f1_valid_q <= item_valid_q;
        f2_valid_q <= f1_valid_q;
        f3_valid_q <= f2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_w_q <= q_w_i;
      in_x_q <= q_x_i;
      in_y_q <= q_y_i;
      in_z_q <= q_z_i;
    end
    if (load) begin
      a_q   <= in_w_q;
      b_q   <= in_x_q;
      c_q   <= in_y_q;
      d_q   <= in_z_q;
      sqa_q <= p_aa[qrj_pkg::SQ_W-1:0];
      sqb_q <= p_bb[qrj_pkg::SQ_W-1:0];
      sqc_q <= p_cc[qrj_pkg::SQ_W-1:0];
      sqd_q <= p_dd[qrj_pkg::SQ_W-1:0];
      ab_q  <= in_w_q * in_x_q;
      cd_q  <= in_y_q * in_z_q;
    end
    if (fadv) begin
      f1_x_q    <= sel_x;
      f1_y_q    <= sel_y;
      f1_l_q    <= sel_l;
      f1_pair_q <= sel_pair;
      f1_tsgn_q <= cfg.tsgn;
      f1_quad_q <= cfg.quad;
      f1_idx_q  <= item_idx_q;
      f1_last_q <= (item_idx_q == qrj_pkg::LAST_IDX);
      f1_s_q    <= norm_sq;
      f2_xl_q   <= f2_xl_d;
      f2_tri_q  <= f2_tri_d;
      f2_tsgn_q <= f1_tsgn_q;
      f2_quad_q <= f1_quad_q;
      f2_idx_q  <= f1_idx_q;
      f2_last_q <= f1_last_q;
      f2_zero_q <= (f1_s_q == '0);
      f2_hh_q   <= f2_hh_d;
      f2_hl_q   <= f2_hl_d;
      f2_ll_q   <= f2_ll_d;
      f3_q      <= f3_d;
    end
  end

endmodule

FILE: src/qrj_back.sv
module qrj_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_empty_i,
  output logic                mid_pop_o,
  input  qrj_pkg::mid_entry_t mid_data_i,
  input  logic                out_full_i,
  output logic                out_push_o,
  output qrj_pkg::out_entry_t out_data_o
);

  localparam int Steps = qrj_pkg::Q_W;

  typedef struct packed {
    logic [qrj_pkg::IDX_W-1:0] idx;
    logic                      last;
    logic                      zero;
    logic                      neg;
    logic                      ovf;
    logic [qrj_pkg::D_W-1:0]   d;
    logic [qrj_pkg::D_W-1:0]   r;
    logic [qrj_pkg::Q_W-1:0]   qn;
  } div_t;

  div_t st_q [Steps+1];
  div_t st_d [Steps+1];
  logic [Steps:0] vld_q;
  logic badv;

  logic signed [qrj_pkg::V_W-1:0] mag;
  logic [qrj_pkg::M_W-1:0] m;

  logic res_valid_q;
  qrj_pkg::out_entry_t res_q, res_d;
  logic [qrj_pkg::Q_W:0]   inc;
  logic [qrj_pkg::Q_W-1:0] rr;

  // one restoring step: bring down the next numerator bit, subtract if it fits
  function automatic div_t div_step(input div_t s);
    div_t o;
    logic [qrj_pkg::D_W:0] t;
    logic ge;
    o  = s;
    t  = {s.r, s.qn[qrj_pkg::Q_W-1]};
    ge = (t >= {1'b0, s.d});
    if (ge) begin
      o.r = qrj_pkg::D_W'(t - {1'b0, s.d});
    end else begin
      o.r = t[qrj_pkg::D_W-1:0];
    end
    o.qn = {s.qn[qrj_pkg::Q_W-2:0], ge};
    return o;
  endfunction

  assign badv       = !res_valid_q || !out_full_i;
  assign out_push_o = res_valid_q && !out_full_i;
  assign mid_pop_o  = badv && !mid_empty_i;
  assign out_data_o = res_q;

  always_comb begin
    mag = mid_data_i.v[qrj_pkg::V_W-1] ? -mid_data_i.v : mid_data_i.v;
    m   = mag[qrj_pkg::M_W-1:0];
    st_d[0].idx  = mid_data_i.idx;
    st_d[0].last = mid_data_i.last;
    st_d[0].zero = mid_data_i.zero;
    st_d[0].neg  = mid_data_i.v[qrj_pkg::V_W-1];
    st_d[0].d    = mid_data_i.d;
    // quotient would need more than the kept bits
    st_d[0].ovf  = ({16'b0, m} >= {mid_data_i.d, 2'b00});
    st_d[0].r    = {16'b0, m[qrj_pkg::M_W-1:2]};
    st_d[0].qn   = {m[1:0], 31'b0};
    for (int i = 0; i < Steps; i++) begin
      st_d[i+1] = div_step(st_q[i]);
    end
  end

  // round half away from zero, then saturate
  always_comb begin
    inc = {1'b0, st_q[Steps].qn} + 1'b1;
    rr  = inc[qrj_pkg::Q_W:1];
    res_d.idx  = st_q[Steps].idx;
    res_d.last = st_q[Steps].last;
    res_d.zero = st_q[Steps].zero;
    if (st_q[Steps].zero) begin
      res_d.value = '0;
    end else if (st_q[Steps].neg) begin
      if (st_q[Steps].ovf || rr > {1'b0, qrj_pkg::SAT_NEG}) begin
        res_d.value = qrj_pkg::SAT_NEG;
      end else begin
        res_d.value = 32'd0 - rr[qrj_pkg::OUT_W-1:0];
      end
    end else begin
      if (st_q[Steps].ovf || rr > {1'b0, qrj_pkg::SAT_POS}) begin
        res_d.value = qrj_pkg::SAT_POS;
      end else begin
        res_d.value = rr[qrj_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (badv) begin
      vld_q       <= {vld_q[Steps-1:0], !mid_empty_i};
      res_valid_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (badv) begin
      st_q  <= st_d;
      res_q <= res_d;
    end
  end

endmodule

FILE: dv/quaternion_rotation_jacobian_tb.sv
module quaternion_rotation_jacobian_tb;

  localparam int NumRandom  = 500;
  localparam int StallLimit = 20000;
  localparam int DrainWait  = 200;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] value;
    logic        last;
    logic        zero;
  } deriv_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        typed;   // row carries a hand-written expected value
    logic [31:0] want;    // value expected for the row's last element
    logic        want_zero;
  } quat_row_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic signed [15:0] q_w, q_x, q_y, q_z;
  logic               empty;
  logic               pop;
  logic [4:0]         element_index;
  logic [31:0]        deriv_value;
  logic               is_last;
  logic               zero_norm;

  deriv_t    expected_derivs[$];
  quat_row_t directed_rows[$];
  int        mismatches;
  int        idle_cycles;
  bit        calm;      // no idling on either side while set

  quaternion_rotation_jacobian i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .q_w_i          (q_w),
    .q_x_i          (q_x),
    .q_y_i          (q_y),
    .q_z_i          (q_z),
    .empty          (empty),
    .pop            (pop),
    .element_index_o(element_index),
    .deriv_value_o  (deriv_value),
    .is_last_o      (is_last),
    .zero_norm_o    (zero_norm)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Scale one polynomial value to Q16.16: v * 2^30 / s^2, round to nearest with
  // ties away from zero, saturate. Widths are generous: |v| < 2^52, s^2 < 2^66.
  function automatic logic [31:0] scale_to_q16(input logic signed [63:0] v,
                                               input logic [63:0] s);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] den;
    logic [127:0] quo;
    logic [127:0] r;
    neg = v < 0;
    mag = neg ? 128'(-v) : 128'(v);
    den = 128'(s) * 128'(s);
    quo = (mag << 31) / den;  // twice the exact value, floored
    r = (quo + 1) >> 1;
    if (neg) begin
      if (r > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-r);
    end
    if (r > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return r[31:0];
  endfunction

  // Work out the 24 derivatives of one quaternion and queue them.
  task automatic predict_derivs(input logic signed [15:0] qw, qx, qy, qz);
    logic signed [63:0] a, b, c, d, a2, b2, c2, d2;
    logic signed [63:0] abc, abd, acd, bcd;
    logic signed [63:0] h33, h34, h35, h36, h37, h38, h44, h45, h47, h50, h51, h62;
    logic signed [63:0] v[24];
    logic [63:0]        s;
    deriv_t             e;
    a = qw; b = qx; c = qy; d = qz;
    a2 = a * a; b2 = b * b; c2 = c * c; d2 = d * d;
    s = a2 + b2 + c2 + d2;
    abc = a * b * c; abd = a * b * d; acd = a * c * d; bcd = b * c * d;
    h33 = d * a2 - d * b2 - d * c2 - d * d2;
    h37 = c * a2 - c * b2;
    h47 = -c * c2 - c * d2;
    h34 = h37 - h47;
    h38 = b * d2 - b * c2;
    h50 = b * a2 + b * b2;
    h35 = h38 + h50;
    h44 = a * b2 + a * a2;
    h45 = a * d2 - a * c2;
    h36 = h44 - h45;
    h51 = d * a2 + d * d2;
    h62 = (b2 - c2) * d;
    v[0]  = 4 * a * (c2 + d2);
    v[1]  = -2 * (2 * abc + h33);
    v[2]  = 2 * (-2 * abc + h33);
    v[3]  = 4 * a * (b2 + d2);
    v[4]  = -2 * (2 * abd + h37 + h47);
    v[5]  = 2 * (b * a2 - b * b2 - b * c2 - b * d2 - 2 * acd);
    v[6]  = 4 * b * (c2 + d2);
    v[7]  = 2 * (-2 * abd + h34);
    v[8]  = 2 * (2 * abd + h34);
    v[9]  = -4 * b * (a2 + c2);
    v[10] = 2 * (-2 * abc - h62 + h51);
    v[11] = -2 * (a * a2 - a * b2 + a * c2 + a * d2 + 2 * bcd);
    v[12] = -4 * c * (a2 + b2);
    v[13] = 2 * (-2 * acd + h35);
    v[14] = 2 * (2 * acd + h35);
    v[15] = 4 * c * (b2 + d2);
    v[16] = 2 * (-2 * bcd + h44 + h45);
    v[17] = 2 * (2 * abc + h62 + h51);
    v[18] = -4 * d * (a2 + b2);
    v[19] = 2 * (-2 * bcd + h36);
    v[20] = -2 * (2 * bcd + h36);
    v[21] = -4 * d * (a2 + c2);
    v[22] = 2 * (-2 * acd - h38 + h50);
    v[23] = 2 * (c * a2 + c * b2 + c * c2 - c * d2 + 2 * abd);
    for (int k = 0; k < 24; k++) begin
      e.idx   = 5'(k);
      e.value = (s == 0) ? 32'd0 : scale_to_q16(v[k], s);
      e.last  = (k == 23);
      e.zero  = (s == 0);
      expected_derivs.push_back(e);
    end
  endtask

  // Present one request and hold it until accepted; idle at random first.
  task automatic send_quat(input logic [15:0] qw, qx, qy, qz);
    while (!calm && $urandom_range(99) < 28) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    q_w  <= qw;
    q_x  <= qx;
    q_y  <= qy;
    q_z  <= qz;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_derivs(qw, qx, qy, qz);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(15));          // tiny: large derivatives
      3: return 16'(-$urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: random stalls, compare each popped result with the oldest
  // expectation.
  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    deriv_t got, exp_d;
    if (rst_n && pop && !empty) begin
      got = '{element_index, deriv_value, is_last, zero_norm};
      if (expected_derivs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result idx=%0d value=%h", got.idx, got.value);
      end else begin
        exp_d = expected_derivs.pop_front();
        if (got !== exp_d) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp idx=%0d val=%h last=%b zero=%b, ",
                      "got idx=%0d val=%h last=%b zero=%b"},
                     exp_d.idx, exp_d.value, exp_d.last, exp_d.zero,
                     got.idx, got.value, got.last, got.zero);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a request.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    quat_row_t row;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    q_w = '0; q_x = '0; q_y = '0; q_z = '0;
    mismatches = 0;
    idle_cycles = 0;
    calm = 1'b0;

    // Directed rows: zero quaternion (error flag, values forced zero), then extremes,
    // unit axes and sign patterns checked against the predictor, then zero again.
    directed_rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd0, 1'b1});
    directed_rows.push_back('{16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0000, 16'h4000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 1'b0, 32'd0, 1'b0});
    directed_rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd0, 1'b1});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_quat(row.w, row.x, row.y, row.z);
      // typed rows must agree with the predictor: guards the predictor itself
      if (row.typed && expected_derivs[$].value !== row.want
          || row.typed && expected_derivs[$].zero !== row.want_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("typed row %0d: exp val=%h zero=%b, predicted val=%h zero=%b",
                   i, row.want, row.want_zero,
                   expected_derivs[$].value, expected_derivs[$].zero);
      end
    end

    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 200 && n < 260);  // stretch with no idling on either side
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    calm = 1'b0;
    push <= 1'b0;

    // Drain: wait for every expected result, then a little extra.
    while (expected_derivs.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (mismatches == 0 && expected_derivs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/qrj_pkg.sv
src/qrj_fifo.sv
src/qrj_front.sv
src/qrj_back.sv
src/quaternion_rotation_jacobian.sv
dv/quaternion_rotation_jacobian_tb.sv
